// File: rtl/core/pea_pkg.sv
// Shared types and constants for the context ID allocator.
// Used by pcid_epoch_allocator and pea_probe in rtl/core; depends on nothing else.
`default_nettype none

package pea_pkg;

    localparam int ID_W        = 32;
    localparam int CTX_W       = 12;
    localparam int EPOCH_W     = 32;
    localparam int NCTX_W      = 13;
    localparam int MAX_CONTEXT = 4095;

    // The home slot is the low identifier bits, so the table depth is a power of two.
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int ENTRY_W = ID_W + CTX_W + EPOCH_W;

    // Request kinds.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_INVAL = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    space;
        logic [CTX_W-1:0]   ctx;
        logic [EPOCH_W-1:0] epoch;
    } entry_t;

    typedef struct packed {
        logic stale;
        logic hit;
    } probe_status_t;

endpackage

`default_nettype wire

// File: rtl/core/pcid_epoch_allocator.sv
// Top level of the context ID allocator: probe sequencer, epoch state and result
// registers. Depends on pea_pkg, pea_ram and pea_probe.
`default_nettype none

// Usage
// A request (kind, space_id) is taken at a rising edge where start is high and
// busy is low. Kind 0 loads (finds or assigns a context ID), kind 1 queries,
// kind 2 invalidates; kind 3 does nothing and returns all zeros.
// Each request gives exactly one result: done is high for one cycle with
// context_id, found, reuse_no_flush and flush_all valid in that cycle. The
// receiver cannot stall, so nothing is ever held back.
// Timing: the table sits in one RAM with a registered read, and the sequencer
// examines one slot per cycle through a single compare unit. When a request
// finishes, done rises in the same cycle that busy drops, so a new request can
// be taken while done is high.
// Kind 3 answers from the idle state without probing, and busy stays low. A load
// that runs out of IDs or free slots restarts its probe once, which costs one
// more probe. If the epoch counter wraps, the load also sweeps all 4096 slots,
// one per cycle, and passes through an issue state that rereads its home slot before it retries.
// Reset: after rst_n is released the block clears the epoch field of every
// slot, one slot per cycle; busy is high during that pass.
module pcid_epoch_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  kind,
    input  wire logic [pea_pkg::ID_W-1:0]    space_id,
    output logic                             done,
    output logic      [pea_pkg::CTX_W-1:0]   context_id,
    output logic                             found,
    output logic                             reuse_no_flush,
    output logic                             flush_all
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_ISSUE = 2'd3;

    localparam logic [pea_pkg::IDX_W-1:0] LAST_IDX = pea_pkg::IDX_W'(pea_pkg::TABLE_ENTRIES - 1);

    logic [1:0]                    state_reg, state_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [pea_pkg::ID_W-1:0]      id_reg, id_next;
    logic [pea_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [pea_pkg::IDX_W-1:0]     n_reg, n_next;
    logic [pea_pkg::IDX_W-1:0]     clr_reg, clr_next;
    logic [pea_pkg::EPOCH_W-1:0]   cur_reg, cur_next;
    logic [pea_pkg::NCTX_W-1:0]    nctx_reg, nctx_next;
    logic                          flush_reg, flush_next;
    logic                          retry_reg, retry_next;
    logic                          done_reg, done_next;
    logic [pea_pkg::CTX_W-1:0]     ctx_out_reg, ctx_out_next;
    logic                          found_reg, found_next;
    logic                          reuse_reg, reuse_next;
    logic                          flush_out_reg, flush_out_next;

    logic                          ram_we;
    logic [pea_pkg::IDX_W-1:0]     ram_waddr;
    pea_pkg::entry_t               ram_wdata;
    logic [pea_pkg::IDX_W-1:0]     ram_raddr;
    pea_pkg::entry_t               ram_rdata;
    pea_pkg::probe_status_t        probe;

    logic [pea_pkg::IDX_W-1:0]     home_id;
    logic [pea_pkg::IDX_W-1:0]     idx_inc;

    pea_ram #(
        .WIDTH (pea_pkg::ENTRY_W),
        .DEPTH (pea_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pea_probe u_probe (
        .entry     (ram_rdata),
        .id        (id_reg),
        .cur_epoch (cur_reg),
        .status    (probe)
    );

    // Home slot is the identifier modulo the table depth.
    assign home_id = id_reg[pea_pkg::IDX_W-1:0];
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign context_id     = ctx_out_reg;
    assign found          = found_reg;
    assign reuse_no_flush = reuse_reg;
    assign flush_all      = flush_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        nctx_next      = nctx_reg;
        flush_next     = flush_reg;
        retry_next     = retry_reg;
        done_next      = 1'b0;
        ctx_out_next   = ctx_out_reg;
        found_next     = found_reg;
        reuse_next     = reuse_reg;
        flush_out_next = flush_out_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        ram_raddr = home_id;

        case (state_reg)
            S_CLEAR:
            begin
                // Writing zeros marks the slot stale in every later epoch.
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = retry_reg ? S_ISSUE : S_IDLE;
                    retry_next = 1'b0;
                end
            end

            S_ISSUE:
            begin
                // Start the retried load from its home slot.
                ram_raddr  = home_id;
                idx_next   = home_id;
                n_next     = '0;
                state_next = S_EVAL;
            end

            S_IDLE:
            begin
                ram_raddr = space_id[pea_pkg::IDX_W-1:0];
                if (start)
                begin
                    kind_next  = kind;
                    id_next    = space_id;
                    idx_next   = space_id[pea_pkg::IDX_W-1:0];
                    n_next     = '0;
                    flush_next = 1'b0;
                    if (kind inside {pea_pkg::KIND_LOAD, pea_pkg::KIND_QUERY,
                                     pea_pkg::KIND_INVAL})
                    begin
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        // Unused kind: answer at once with an all-zero result.
                        done_next      = 1'b1;
                        ctx_out_next   = '0;
                        found_next     = 1'b0;
                        reuse_next     = 1'b0;
                        flush_out_next = 1'b0;
                    end
                end
            end

            S_EVAL:
            begin
                // Default: move on to the next slot, read it for the next cycle.
                ram_raddr = idx_inc;
                idx_next  = idx_inc;
                n_next    = n_reg + 1'b1;

                case (kind_reg)
                    pea_pkg::KIND_LOAD:
                    begin
                        if (probe.hit)
                        begin
                            done_next      = 1'b1;
                            ctx_out_next   = ram_rdata.ctx;
                            found_next     = 1'b1;
                            reuse_next     = 1'b1;
                            flush_out_next = flush_reg;
                            state_next     = S_IDLE;
                        end
                        else if (probe.stale &&
                                 nctx_reg <= pea_pkg::NCTX_W'(pea_pkg::MAX_CONTEXT))
                        begin
                            // Claim the stale slot with the next free ID.
                            ram_we          = 1'b1;
                            ram_waddr       = idx_reg;
                            ram_wdata.space = id_reg;
                            ram_wdata.ctx   = nctx_reg[pea_pkg::CTX_W-1:0];
                            ram_wdata.epoch = cur_reg;
                            nctx_next       = nctx_reg + 1'b1;
                            done_next       = 1'b1;
                            ctx_out_next    = nctx_reg[pea_pkg::CTX_W-1:0];
                            found_next      = 1'b0;
                            reuse_next      = 1'b0;
                            flush_out_next  = flush_reg;
                            state_next      = S_IDLE;
                        end
                        else if (probe.stale || n_reg == LAST_IDX)
                        begin
                            // IDs or slots exhausted: new epoch, full flush, retry.
                            flush_next = 1'b1;
                            nctx_next  = pea_pkg::NCTX_W'(1);
                            ram_raddr  = home_id;
                            idx_next   = home_id;
                            n_next     = '0;
                            if (cur_reg == '1)
                            begin
                                // Epoch wraps: every slot must be made stale first.
                                cur_next   = pea_pkg::EPOCH_W'(1);
                                clr_next   = '0;
                                retry_next = 1'b1;
                                state_next = S_CLEAR;
                            end
                            else
                            begin
                                cur_next = cur_reg + 1'b1;
                            end
                        end
                    end

                    pea_pkg::KIND_QUERY, pea_pkg::KIND_INVAL:
                    begin
                        if (probe.hit)
                        begin
                            if (kind_reg == pea_pkg::KIND_INVAL)
                            begin
                                // Keep the slot current so probe chains stay intact.
                                ram_we          = 1'b1;
                                ram_waddr       = idx_reg;
                                ram_wdata       = ram_rdata;
                                ram_wdata.space = '0;
                            end
                            done_next      = 1'b1;
                            ctx_out_next   = ram_rdata.ctx;
                            found_next     = 1'b1;
                            reuse_next     = 1'b0;
                            flush_out_next = 1'b0;
                            state_next     = S_IDLE;
                        end
                        else if (probe.stale || n_reg == LAST_IDX)
                        begin
                            done_next      = 1'b1;
                            ctx_out_next   = '0;
                            found_next     = 1'b0;
                            reuse_next     = 1'b0;
                            flush_out_next = 1'b0;
                            state_next     = S_IDLE;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            kind_reg      <= '0;
            id_reg        <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            clr_reg       <= '0;
            cur_reg       <= pea_pkg::EPOCH_W'(1);
            nctx_reg      <= pea_pkg::NCTX_W'(1);
            flush_reg     <= 1'b0;
            retry_reg     <= 1'b0;
            done_reg      <= 1'b0;
            ctx_out_reg   <= '0;
            found_reg     <= 1'b0;
            reuse_reg     <= 1'b0;
            flush_out_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            id_reg        <= id_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            nctx_reg      <= nctx_next;
            flush_reg     <= flush_next;
            retry_reg     <= retry_next;
            done_reg      <= done_next;
            ctx_out_reg   <= ctx_out_next;
            found_reg     <= found_next;
            reuse_reg     <= reuse_next;
            flush_out_reg <= flush_out_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pea_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module pea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/pea_probe.sv
// Compare unit shared by every probe step: checks one table entry against
// the request identifier and the current epoch. Depends on pea_pkg.
`default_nettype none

module pea_probe (
    input  wire pea_pkg::entry_t              entry,
    input  wire logic [pea_pkg::ID_W-1:0]     id,
    input  wire logic [pea_pkg::EPOCH_W-1:0]  cur_epoch,
    output pea_pkg::probe_status_t            status
);

    // An identifier of zero marks empty and invalidated slots and never matches.
    always_comb
    begin
        status.stale = (entry.epoch != cur_epoch);
        status.hit   = (entry.epoch == cur_epoch) && (id != '0) && (entry.space == id);
    end

endmodule

`default_nettype wire

// File: tb/pcid_epoch_allocator_checker.sv
// Scoreboard for the context ID allocator: mirrors the slot table and the epoch state,
// predicts the result of every accepted request and compares it with the block's output.
// Depends on pea_pkg only.
`timescale 1ns / 100ps

module pcid_epoch_allocator_checker
    import pea_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [1:0]        kind,
    input  wire logic [ID_W-1:0]   space_id,
    input  wire logic              done,
    input  wire logic [CTX_W-1:0]  context_id,
    input  wire logic              found,
    input  wire logic              reuse_no_flush,
    input  wire logic              flush_all,
    output int                     fail_count,
    output int                     pending_results
);

    typedef struct packed {
        logic [CTX_W-1:0] ctx;
        logic             found;
        logic             reuse;
        logic             flush;
    } alloc_result_t;

    logic [ID_W-1:0]    mirror_space [TABLE_ENTRIES];
    logic [CTX_W-1:0]   mirror_ctx   [TABLE_ENTRIES];
    logic [EPOCH_W-1:0] mirror_epoch [TABLE_ENTRIES];
    logic [EPOCH_W-1:0] live_epoch;
    logic [NCTX_W-1:0]  next_ctx;

    alloc_result_t expected_results [$];

    function automatic void bump_epoch();
        int i;
        live_epoch = live_epoch + 1'b1;
        if (live_epoch == '0)
        begin
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                mirror_epoch[i[IDX_W-1:0]] = '0;
            end
            live_epoch = EPOCH_W'(1);
        end
        next_ctx = NCTX_W'(1);
    endfunction

    // Slot of a current entry holding id, or -1. The walk ends at the first stale slot.
    function automatic int lookup_slot(input logic [ID_W-1:0] id);
        logic [IDX_W-1:0] idx;
        int slot;
        int n;
        bit stop;
        idx  = id[IDX_W-1:0];
        slot = -1;
        stop = 1'b0;
        for (n = 0; n < TABLE_ENTRIES && !stop; n++)
        begin
            if (mirror_epoch[idx] != live_epoch)
            begin
                stop = 1'b1;
            end
            else if (id != '0 && mirror_space[idx] == id)
            begin
                slot = int'(idx);
                stop = 1'b1;
            end
            else
            begin
                idx = idx + 1'b1;
            end
        end
        return slot;
    endfunction

    function automatic alloc_result_t serve_request(input logic [1:0] k,
                                                    input logic [ID_W-1:0] id);
        alloc_result_t res;
        logic [IDX_W-1:0] idx;
        bit settled;
        bit stop;
        int slot;
        int attempt;
        int n;
        res = '0;
        case (k)
            KIND_LOAD:
            begin
                settled = 1'b0;
                for (attempt = 0; attempt < 2 && !settled; attempt++)
                begin
                    idx  = id[IDX_W-1:0];
                    stop = 1'b0;
                    for (n = 0; n < TABLE_ENTRIES && !stop; n++)
                    begin
                        if (mirror_epoch[idx] == live_epoch)
                        begin
                            if (id != '0 && mirror_space[idx] == id)
                            begin
                                res.ctx   = mirror_ctx[idx];
                                res.found = 1'b1;
                                res.reuse = 1'b1;
                                settled   = 1'b1;
                                stop      = 1'b1;
                            end
                            else
                            begin
                                idx = idx + 1'b1;
                            end
                        end
                        else
                        begin
                            // A stale slot is free, but only usable while IDs remain.
                            stop = 1'b1;
                            if (next_ctx <= MAX_CONTEXT)
                            begin
                                res.ctx           = next_ctx[CTX_W-1:0];
                                next_ctx          = next_ctx + 1'b1;
                                mirror_space[idx] = id;
                                mirror_ctx[idx]   = res.ctx;
                                mirror_epoch[idx] = live_epoch;
                                settled           = 1'b1;
                            end
                        end
                    end
                    if (!settled)
                    begin
                        bump_epoch();
                        res.flush = 1'b1;
                    end
                end
            end
            KIND_QUERY:
            begin
                slot = lookup_slot(id);
                if (slot >= 0)
                begin
                    res.ctx   = mirror_ctx[slot[IDX_W-1:0]];
                    res.found = 1'b1;
                end
            end
            KIND_INVAL:
            begin
                slot = lookup_slot(id);
                if (slot >= 0)
                begin
                    res.ctx                        = mirror_ctx[slot[IDX_W-1:0]];
                    res.found                      = 1'b1;
                    mirror_space[slot[IDX_W-1:0]]  = '0;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CTX_W-1:0] want,
                               input logic [CTX_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        alloc_result_t want;
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                mirror_space[i[IDX_W-1:0]] = '0;
                mirror_ctx[i[IDX_W-1:0]]   = '0;
                mirror_epoch[i[IDX_W-1:0]] = '0;
            end
            live_epoch = EPOCH_W'(1);
            next_ctx   = NCTX_W'(1);
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            // A result leaves before the next request can enter, so compare first.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: context_id %0d", context_id);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("context_id", want.ctx, context_id);
                    check_field("found", CTX_W'(want.found), CTX_W'(found));
                    check_field("reuse_no_flush", CTX_W'(want.reuse), CTX_W'(reuse_no_flush));
                    check_field("flush_all", CTX_W'(want.flush), CTX_W'(flush_all));
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(serve_request(kind, space_id));
            end
        end
        pending_results = expected_results.size();
    end

endmodule

// File: tb/pcid_epoch_allocator_test.sv
// Top of the context ID allocator regression: clock, reset, request stimulus and verdict.
// Depends on pea_pkg, the allocator RTL and pcid_epoch_allocator_checker.
`timescale 1ns / 100ps

module pcid_epoch_allocator_test;

    import pea_pkg::*;

    // The package names only the three defined kinds; the fourth code must do nothing.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RUN_ITEMS   = 1250;
    localparam int POOL_SIZE   = 48;
    localparam int POOL_W      = $clog2(POOL_SIZE);
    localparam int BURST_LIMIT = 4300;

    // Slowest correct run, roughly: the clearing pass after reset, about 4100 burst
    // loads of under ten probes each, a query and a load that walk almost the whole
    // table, and 1250 random requests whose probe chains stay within a few hundred
    // slots, plus idle gaps. The limit allows several times what that takes.
    localparam int CYCLE_LIMIT = 4_000_000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       kind;
    logic [ID_W-1:0]  space_id;
    logic             done;
    logic [CTX_W-1:0] context_id;
    logic             found;
    logic             reuse_no_flush;
    logic             flush_all;

    int fail_count;
    int pending_results;
    int cycles;

    // When clear, the sender presents requests back to back.
    bit idle_enable;

    // Set once the block has reported an epoch rollover; the ID exhaustion burst
    // runs until then.
    bit rollover_seen;

    // Identifiers that random requests come back to, so loads hit, queries find
    // entries and invalidations have something to clear. Most share home slots
    // around the top of the table so that chains form and wrap past the last slot.
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    pcid_epoch_allocator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .space_id       (space_id),
        .done           (done),
        .context_id     (context_id),
        .found          (found),
        .reuse_no_flush (reuse_no_flush),
        .flush_all      (flush_all)
    );

    pcid_epoch_allocator_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .space_id        (space_id),
        .done            (done),
        .context_id      (context_id),
        .found           (found),
        .reuse_no_flush  (reuse_no_flush),
        .flush_all       (flush_all),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done && flush_all)
        begin
            rollover_seen <= 1'b1;
        end
    end

    // Presents one request and returns at the falling edge after it was taken, with
    // start still high so that the next request can follow without a gap. Inputs
    // only change at falling edges; busy is stable there, so checking it then tells
    // whether the coming rising edge takes the request.
    task automatic issue(input logic [1:0] k, input logic [ID_W-1:0] id);
        while (idle_enable && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        kind     <= k;
        space_id <= id;
        while (busy)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    // Holds off the sender until every outstanding request has produced its result.
    task automatic drain();
        start <= 1'b0;
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("pcid_epoch_allocator regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [ID_W-1:0] fresh;
        logic [ID_W-1:0] kept_id;
        logic [ID_W-1:0] pick_id;
        logic [1:0]      pick_kind;
        int              n;
        int              roll;

        start       = 1'b0;
        kind        = KIND_LOAD;
        space_id    = '0;
        rst_n       = 1'b0;
        idle_enable = 1'b1;
        kept_id     = '0;

        for (n = 0; n < POOL_SIZE; n++)
        begin
            id_pool[n[POOL_W-1:0]] = $urandom();
            if (n < 32)
            begin
                id_pool[n[POOL_W-1:0]][IDX_W-1:0] = IDX_W'(12'hFFC + $urandom_range(7));
            end
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests. The table starts empty, so a query misses outright.
        issue(KIND_QUERY, 32'h0000_1234);
        // A miss takes the first ID, and a second load of the same space reuses it.
        issue(KIND_LOAD,  32'h0000_1234);
        issue(KIND_LOAD,  32'h0000_1234);
        // Same home slot, different identifier: the probe steps to the next slot.
        issue(KIND_LOAD,  32'h0000_2234);
        issue(KIND_QUERY, 32'h0000_2234);
        // Invalidating the head of the chain must not cut the chain behind it.
        issue(KIND_INVAL, 32'h0000_1234);
        issue(KIND_QUERY, 32'h0000_1234);
        issue(KIND_QUERY, 32'h0000_2234);
        issue(KIND_LOAD,  32'h0000_1234);
        issue(KIND_INVAL, 32'h0000_1234);
        // The last slot and a probe that wraps around to slot zero.
        issue(KIND_LOAD,  32'hFFFF_FFFF);
        issue(KIND_LOAD,  32'h0000_0FFF);
        issue(KIND_QUERY, 32'h0000_0FFF);
        issue(KIND_QUERY, 32'hFFFF_FFFF);
        // The zero identifier never matches, yet a load with it still takes an ID.
        issue(KIND_LOAD,  32'h0000_0000);
        issue(KIND_LOAD,  32'h0000_0000);
        issue(KIND_QUERY, 32'h0000_0000);
        issue(KIND_INVAL, 32'h0000_0000);
        // The unused kind changes nothing and answers with zeros.
        issue(KIND_UNUSED, 32'hFFFF_FFFF);
        issue(KIND_UNUSED, 32'h0000_1234);
        issue(KIND_INVAL, 32'h8000_0000);
        issue(KIND_QUERY, 32'h0000_0FFF);

        drain();

        // ID exhaustion burst, back to back with no idling. Each load brings a new
        // identifier whose home slot follows the previous one, so the table fills
        // almost completely until the IDs run out and the epoch rolls over.
        idle_enable = 1'b0;
        n = 0;
        while (!rollover_seen && n < BURST_LIMIT)
        begin
            fresh = $urandom();
            fresh[IDX_W-1:0] = n[IDX_W-1:0];
            if (n == 100)
            begin
                kept_id = fresh;
            end
            issue(KIND_LOAD, fresh);
            if (n == 4000)
            begin
                // With the table nearly full: a hit, a found query, a query that walks
                // nearly every slot before reaching a stale one, and a reload after
                // invalidation that must claim a new slot past the cluster.
                issue(KIND_LOAD, kept_id);
                issue(KIND_QUERY, kept_id);
                fresh = $urandom();
                fresh[IDX_W-1:0] = '0;
                issue(KIND_QUERY, fresh);
                issue(KIND_INVAL, kept_id);
                issue(KIND_LOAD, kept_id);
            end
            n++;
        end

        // After the rollover every older entry is stale.
        issue(KIND_QUERY, kept_id);
        issue(KIND_LOAD, kept_id);
        issue(KIND_LOAD, kept_id);

        // Random requests. Most reuse the pool so that hits, chains and invalidated
        // slots build up; the rest bring fresh identifiers, the zero identifier and
        // the unused kind.
        idle_enable = 1'b1;
        for (n = 0; n < RUN_ITEMS; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                pick_kind = KIND_LOAD;
            end
            else if (roll < 70)
            begin
                pick_kind = KIND_QUERY;
            end
            else if (roll < 92)
            begin
                pick_kind = KIND_INVAL;
            end
            else
            begin
                pick_kind = KIND_UNUSED;
            end

            roll = $urandom_range(99);
            if (roll < 80)
            begin
                pick_id = id_pool[POOL_W'($urandom_range(POOL_SIZE - 1))];
            end
            else if (roll < 96)
            begin
                pick_id = $urandom();
            end
            else
            begin
                pick_id = '0;
            end

            if (n == RUN_ITEMS / 2)
            begin
                drain();
            end
            issue(pick_kind, pick_id);
        end

        // Let every outstanding result arrive, then watch a little longer for stray ones.
        drain();
        repeat (16) @(negedge clk);

        if (fail_count == 0 && pending_results == 0)
        begin
            $display("pcid_epoch_allocator regression: pass");
        end
        else
        begin
            $display("pcid_epoch_allocator regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/pea_pkg.sv
rtl/core/pea_ram.sv
rtl/core/pea_probe.sv
rtl/core/pcid_epoch_allocator.sv
tb/pcid_epoch_allocator_checker.sv
tb/pcid_epoch_allocator_test.sv
